>>> rtl/eihp_pkg.sv
// shared types and constants for the ethernet ii / ipv4 header parser
// no dependencies
package eihp_pkg;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_IPV4  = 2'd1,
    KIND_ARP   = 2'd2,
    KIND_OTHER = 2'd3
  } ether_kind_t;

  typedef enum logic [3:0] {
    VERDICT_UDP_OK      = 4'd0,
    VERDICT_ARP         = 4'd1,
    VERDICT_OTHER_TYPE  = 4'd2,
    VERDICT_BAD_VERSION = 4'd3,
    VERDICT_SHORT_HDR   = 4'd4,
    VERDICT_CHECKSUM    = 4'd5,
    VERDICT_FRAGMENT    = 4'd6,
    VERDICT_NOT_OURS    = 4'd7,
    VERDICT_NON_UDP     = 4'd8,
    VERDICT_TRUNCATED   = 4'd9
  } verdict_t;

  localparam logic [7:0]  VERSION_MASK   = 8'hF0;
  localparam logic [7:0]  VERSION_IPV4   = 8'h40;
  localparam logic [7:0]  IHL_MASK       = 8'h0F;
  localparam logic [15:0] FRAG_MASK      = 16'hBFFF;
  localparam logic [31:0] BROADCAST_IPV4 = 32'hFFFFFFFF;
  localparam logic [7:0]  PROTO_UDP      = 8'h11;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
  localparam logic [15:0] CSUM_GOOD      = 16'hFFFF;

  localparam logic [6:0] POS_SRC_MAC = 7'd6;
  localparam logic [6:0] POS_TYPE_HI = 7'd12;
  localparam logic [6:0] POS_TYPE_LO = 7'd13;
  localparam logic [6:0] POS_IP      = 7'd14;
  localparam logic [6:0] POS_MAX     = 7'd127;
  localparam logic [5:0] MIN_IHL     = 6'd20;

  // per-frame parse state; first_failure holds VERDICT_UDP_OK while no failure
  typedef struct packed {
    logic [6:0]  byte_position;
    logic [5:0]  header_bytes;
    logic [15:0] running_checksum;
    logic [15:0] pseudo_partial;
    verdict_t    first_failure;
    ether_kind_t ether_kind;
    logic [47:0] captured_mac;
    logic [31:0] captured_source_ip;
    logic [31:0] captured_destination_ip;
    logic [15:0] total_length;
    logic [7:0]  protocol_number;
    logic [15:0] flags_fragment_word;
  } frame_state_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] destination_ip;
    logic [15:0] pseudo_header_sum;
    logic [15:0] payload_length;
    logic [6:0]  payload_offset;
  } result_t;

endpackage

>>> rtl/eth_ipv4_header_parser.sv
// top level of the ethernet ii / ipv4 header parser: input register, result register
// depends on eihp_pkg, eihp_frame_tracker, eihp_verdict_unit
//
// usage:
//   input channel (in_valid/in_ready) carries one frame byte per item with
//   last_byte set on the final byte of the frame, starting at the dest mac.
//   output channel (out_valid/out_ready) carries one result item per frame,
//   produced from the byte marked last; other bytes produce no result.
//   config_write/config_data load the local ipv4 address;
//   write it only while the parser is idle.
// timing:
//   one byte per cycle sustained unless a last byte is held (see stall). a byte
//   sits in the input register; the frame state and the result register update
//   at the edge that moves it on, which for a last byte loads its result.
// reset (rst, synchronous): clears frame state, both valid flags and the
//   local address.
// stall: while a result waits on out_ready, non-last bytes keep flowing; a
//   last byte is held in the input register and in_ready drops until the
//   waiting result is taken.
module eth_ipv4_header_parser import eihp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  verdict,
  output logic [47:0] source_mac,
  output logic [31:0] source_ip,
  output logic [31:0] destination_ip,
  output logic [15:0] pseudo_header_sum,
  output logic [15:0] payload_length,
  output logic [6:0]  payload_offset,
  input  logic        config_write,
  input  logic [31:0] config_data
);

  logic         s1_valid;
  logic [7:0]   s1_byte;
  logic         s1_last;
  logic         s1_go;
  logic         out_free;
  logic [31:0]  local_ipv4_address;
  frame_state_t state_next;
  result_t      res;
  result_t      out_res;

  assign out_free = !out_valid || out_ready;
  assign s1_go = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ipv4_address <= '0;
    end else if (config_write) begin
      local_ipv4_address <= config_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= frame_byte;
      s1_last <= last_byte;
    end
  end

  eihp_frame_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .step       (s1_go),
    .frame_byte (s1_byte),
    .last_byte  (s1_last),
    .state_next (state_next)
  );

  eihp_verdict_unit u_verdict (
    .st                 (state_next),
    .local_ipv4_address (local_ipv4_address),
    .res                (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      out_res <= res;
    end
  end

  assign verdict           = out_res.verdict;
  assign source_mac        = out_res.source_mac;
  assign source_ip         = out_res.source_ip;
  assign destination_ip    = out_res.destination_ip;
  assign pseudo_header_sum = out_res.pseudo_header_sum;
  assign payload_length    = out_res.payload_length;
  assign payload_offset    = out_res.payload_offset;

  a_ready_only_blocked_by_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && s1_last && out_valid && !out_ready))
    else $error("input stalled without a pending result");

  a_result_from_last_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("result raised without a last byte");

  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.verdict <= VERDICT_TRUNCATED))
    else $error("verdict code out of range");

  a_ip_fields_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((out_res.verdict == VERDICT_ARP) ||
                   (out_res.verdict == VERDICT_OTHER_TYPE) ||
                   (out_res.verdict == VERDICT_BAD_VERSION) ||
                   (out_res.verdict == VERDICT_SHORT_HDR) ||
                   (out_res.verdict == VERDICT_TRUNCATED)))
    |-> ((payload_offset == 7'd0) && (source_ip == 32'd0) && (payload_length == 16'd0)))
    else $error("ip fields set on a non-ip verdict");

  a_ip_offset_min: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ((out_res.verdict == VERDICT_UDP_OK) ||
                   (out_res.verdict == VERDICT_CHECKSUM) ||
                   (out_res.verdict == VERDICT_FRAGMENT) ||
                   (out_res.verdict == VERDICT_NOT_OURS) ||
                   (out_res.verdict == VERDICT_NON_UDP)))
    |-> (payload_offset >= 7'd34))
    else $error("payload offset below minimum ip header");

endmodule

>>> rtl/eihp_frame_tracker.sv
// per-byte frame state: position, ethertype, ipv4 header fields and running sums
// depends on eihp_pkg
module eihp_frame_tracker import eihp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   frame_byte,
  input  logic         last_byte,
  output frame_state_t state_next
);

  frame_state_t st;
  logic [6:0]   p;
  logic [6:0]   h;
  logic         take;
  logic [15:0]  term;
  logic [16:0]  csum_sum;
  logic [16:0]  pseudo_sum;
  logic [15:0]  ether_type;
  logic [5:0]   ihl_bytes;
  logic         add_pseudo;

  assign p = st.byte_position;
  assign h = p - POS_IP;
  assign term = h[0] ? {8'h00, frame_byte} : {frame_byte, 8'h00};
  assign csum_sum = {1'b0, st.running_checksum} + {1'b0, term};
  assign pseudo_sum = {1'b0, st.pseudo_partial} + {1'b0, term};
  assign ether_type = {st.total_length[7:0], frame_byte};
  assign ihl_bytes = {frame_byte[3:0] & IHL_MASK[3:0], 2'b00};
  assign take = (p >= POS_IP) && (st.ether_kind == KIND_IPV4) &&
                (st.first_failure == VERDICT_UDP_OK) &&
                ((h == 7'd0) || (h < {1'b0, st.header_bytes}));
  assign add_pseudo = (h == 7'd9) || ((h >= 7'd12) && (h < 7'd20));

  always_comb begin
    state_next = st;
    if ((p >= POS_SRC_MAC) && (p < POS_TYPE_HI)) begin
      state_next.captured_mac = {st.captured_mac[39:0], frame_byte};
    end else if (p == POS_TYPE_HI) begin
      state_next.total_length = {8'h00, frame_byte};
    end else if (p == POS_TYPE_LO) begin
      state_next.total_length = '0;
      if (ether_type == ETHERTYPE_IPV4) begin
        state_next.ether_kind = KIND_IPV4;
      end else if (ether_type == ETHERTYPE_ARP) begin
        state_next.ether_kind = KIND_ARP;
      end else begin
        state_next.ether_kind = KIND_OTHER;
      end
    end else if (take) begin
      if ((h == 7'd0) && ((frame_byte & VERSION_MASK) != VERSION_IPV4)) begin
        state_next.first_failure = VERDICT_BAD_VERSION;
      end else if ((h == 7'd0) && (ihl_bytes < MIN_IHL)) begin
        state_next.first_failure = VERDICT_SHORT_HDR;
      end else begin
        if (h == 7'd0) begin
          state_next.header_bytes = ihl_bytes;
        end
        state_next.running_checksum = csum_sum[15:0] + {15'd0, csum_sum[16]};
        if (add_pseudo) begin
          state_next.pseudo_partial = pseudo_sum[15:0] + {15'd0, pseudo_sum[16]};
        end
        if ((h == 7'd2) || (h == 7'd3)) begin
          state_next.total_length = {st.total_length[7:0], frame_byte};
        end else if ((h == 7'd6) || (h == 7'd7)) begin
          state_next.flags_fragment_word = {st.flags_fragment_word[7:0], frame_byte};
        end else if (h == 7'd9) begin
          state_next.protocol_number = frame_byte;
        end else if ((h >= 7'd12) && (h < 7'd16)) begin
          state_next.captured_source_ip = {st.captured_source_ip[23:0], frame_byte};
        end else if ((h >= 7'd16) && (h < 7'd20)) begin
          state_next.captured_destination_ip =
            {st.captured_destination_ip[23:0], frame_byte};
        end
      end
    end
    if (p != POS_MAX) begin
      state_next.byte_position = p + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      if (last_byte) begin
        st <= '0;
      end else begin
        st <= state_next;
      end
    end
  end

endmodule

>>> rtl/eihp_verdict_unit.sv
// end-of-frame classification and result fields from the updated frame state
// depends on eihp_pkg
module eihp_verdict_unit import eihp_pkg::*; (
  input  frame_state_t st,
  input  logic [31:0]  local_ipv4_address,
  output result_t      res
);

  verdict_t    v;
  logic        ip_ok;
  logic [15:0] plen;
  logic [16:0] psum;

  assign plen = st.total_length - {10'd0, st.header_bytes};
  assign psum = {1'b0, st.pseudo_partial} + {1'b0, plen};

  always_comb begin
    if (st.byte_position < POS_IP) begin
      v = VERDICT_TRUNCATED;
    end else if (st.ether_kind == KIND_ARP) begin
      v = VERDICT_ARP;
    end else if (st.ether_kind != KIND_IPV4) begin
      v = VERDICT_OTHER_TYPE;
    end else if (st.first_failure != VERDICT_UDP_OK) begin
      v = st.first_failure;
    end else if ((st.header_bytes == 6'd0) ||
                 (st.byte_position < (POS_IP + {1'b0, st.header_bytes}))) begin
      v = VERDICT_TRUNCATED;
    end else if (st.running_checksum != CSUM_GOOD) begin
      v = VERDICT_CHECKSUM;
    end else if ((st.flags_fragment_word & FRAG_MASK) != 16'd0) begin
      v = VERDICT_FRAGMENT;
    end else if ((st.captured_destination_ip != local_ipv4_address) &&
                 (st.captured_destination_ip != BROADCAST_IPV4)) begin
      v = VERDICT_NOT_OURS;
    end else if (st.protocol_number != PROTO_UDP) begin
      v = VERDICT_NON_UDP;
    end else begin
      v = VERDICT_UDP_OK;
    end
  end

  assign ip_ok = (v == VERDICT_UDP_OK) || (v == VERDICT_CHECKSUM) ||
                 (v == VERDICT_FRAGMENT) || (v == VERDICT_NOT_OURS) ||
                 (v == VERDICT_NON_UDP);

  always_comb begin
    res = '0;
    res.verdict = v;
    res.source_mac = (st.byte_position >= POS_TYPE_HI) ? st.captured_mac : 48'd0;
    if (ip_ok) begin
      res.source_ip = st.captured_source_ip;
      res.destination_ip = st.captured_destination_ip;
      res.pseudo_header_sum = psum[15:0] + {15'd0, psum[16]};
      res.payload_length = plen;
      res.payload_offset = POS_IP + {1'b0, st.header_bytes};
    end
  end

endmodule

>>> dv/eihp_parse_checker.sv
// frame parse checker for eth_ipv4_header_parser: predicts one result per frame
// from the bytes taken on the input channel and compares each result taken on the output
// depends on eihp_pkg
module eihp_parse_checker import eihp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  frame_byte,
  input  logic        last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  verdict,
  input  logic [47:0] source_mac,
  input  logic [31:0] source_ip,
  input  logic [31:0] destination_ip,
  input  logic [15:0] pseudo_header_sum,
  input  logic [15:0] payload_length,
  input  logic [6:0]  payload_offset,
  input  logic        config_write,
  input  logic [31:0] config_data,
  output int          results_due,
  output int          mismatches
);

  result_t     frame_results[$];
  result_t     oldest;
  logic [31:0] own_address;
  logic [6:0]  pos;
  logic [5:0]  hdr_len;
  logic [15:0] hdr_sum;
  verdict_t    first_fail;
  ether_kind_t kind;
  logic [47:0] mac;
  logic [31:0] src_ip;
  logic [31:0] dst_ip;
  logic [15:0] total_len;
  logic [7:0]  proto;
  logic [15:0] frag_word;
  int          fails;

  function automatic logic [15:0] ones_fold(input logic [31:0] s);
    logic [31:0] t;
    t = {16'h0, s[15:0]} + {16'h0, s[31:16]};
    t = {16'h0, t[15:0]} + {16'h0, t[31:16]};
    return t[15:0];
  endfunction

  function automatic int field_differs(input string name, input logic [47:0] want,
                                       input logic [47:0] got);
    if (want === got) return 0;
    $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    return 1;
  endfunction

  task automatic clear_frame();
    pos = '0;
    hdr_len = '0;
    hdr_sum = '0;
    first_fail = VERDICT_UDP_OK;
    kind = KIND_NONE;
    mac = '0;
    src_ip = '0;
    dst_ip = '0;
    total_len = '0;
    proto = '0;
    frag_word = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic mark);
    logic [6:0]  h;
    logic [15:0] ethertype;
    logic [15:0] plen;
    result_t     r;
    bit          ip_ok;
    if (pos >= POS_SRC_MAC && pos < POS_TYPE_HI) begin
      mac = {mac[39:0], b};
    end else if (pos == POS_TYPE_HI) begin
      total_len = {8'h00, b};
    end else if (pos == POS_TYPE_LO) begin
      ethertype = {total_len[7:0], b};
      total_len = '0;
      if (ethertype == ETHERTYPE_IPV4) kind = KIND_IPV4;
      else if (ethertype == ETHERTYPE_ARP) kind = KIND_ARP;
      else kind = KIND_OTHER;
    end else if (pos >= POS_IP && kind == KIND_IPV4 && first_fail == VERDICT_UDP_OK) begin
      h = pos - POS_IP;
      if (h == 7'd0 || h < {1'b0, hdr_len}) begin
        if (h == 7'd0) begin
          if ((b & VERSION_MASK) != VERSION_IPV4) first_fail = VERDICT_BAD_VERSION;
          else if ({b[3:0], 2'b00} < MIN_IHL) first_fail = VERDICT_SHORT_HDR;
          else hdr_len = {b[3:0], 2'b00};
        end
        if (first_fail == VERDICT_UDP_OK) begin
          hdr_sum = ones_fold({16'h0, hdr_sum} + (h[0] ? {24'h0, b} : {16'h0, b, 8'h00}));
          if (h == 7'd2 || h == 7'd3) total_len = {total_len[7:0], b};
          else if (h == 7'd6 || h == 7'd7) frag_word = {frag_word[7:0], b};
          else if (h == 7'd9) proto = b;
          else if (h >= 7'd12 && h < 7'd16) src_ip = {src_ip[23:0], b};
          else if (h >= 7'd16 && h < 7'd20) dst_ip = {dst_ip[23:0], b};
        end
      end
    end
    if (pos < POS_MAX) pos++;
    if (!mark) return;

    if (pos < POS_IP) r.verdict = VERDICT_TRUNCATED;
    else if (kind == KIND_ARP) r.verdict = VERDICT_ARP;
    else if (kind != KIND_IPV4) r.verdict = VERDICT_OTHER_TYPE;
    else if (first_fail != VERDICT_UDP_OK) r.verdict = first_fail;
    else if (hdr_len == 6'd0 || pos < POS_IP + hdr_len) r.verdict = VERDICT_TRUNCATED;
    else if (hdr_sum != CSUM_GOOD) r.verdict = VERDICT_CHECKSUM;
    else if ((frag_word & FRAG_MASK) != 16'h0) r.verdict = VERDICT_FRAGMENT;
    else if (dst_ip != own_address && dst_ip != BROADCAST_IPV4) r.verdict = VERDICT_NOT_OURS;
    else if (proto != PROTO_UDP) r.verdict = VERDICT_NON_UDP;
    else r.verdict = VERDICT_UDP_OK;

    ip_ok = r.verdict == VERDICT_UDP_OK || r.verdict == VERDICT_CHECKSUM ||
            r.verdict == VERDICT_FRAGMENT || r.verdict == VERDICT_NOT_OURS ||
            r.verdict == VERDICT_NON_UDP;
    r.source_mac = (pos >= POS_TYPE_HI) ? mac : '0;
    if (ip_ok) begin
      plen = total_len - {10'h0, hdr_len};
      r.source_ip = src_ip;
      r.destination_ip = dst_ip;
      r.pseudo_header_sum = ones_fold(32'(proto) + 32'(src_ip[31:16]) + 32'(src_ip[15:0]) +
                                      32'(dst_ip[31:16]) + 32'(dst_ip[15:0]) + 32'(plen));
      r.payload_length = plen;
      r.payload_offset = POS_IP + {1'b0, hdr_len};
    end else begin
      r.source_ip = '0;
      r.destination_ip = '0;
      r.pseudo_header_sum = '0;
      r.payload_length = '0;
      r.payload_offset = '0;
    end
    frame_results.push_back(r);
    clear_frame();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      own_address = '0;
      clear_frame();
      frame_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (frame_results.size() == 0) begin
          fails++;
          $display("%0t: result with no frame pending, expected none actual verdict %0d",
                   $time, verdict);
        end else begin
          oldest = frame_results.pop_front();
          fails += field_differs("verdict", oldest.verdict, verdict);
          fails += field_differs("source_mac", oldest.source_mac, source_mac);
          fails += field_differs("source_ip", oldest.source_ip, source_ip);
          fails += field_differs("destination_ip", oldest.destination_ip, destination_ip);
          fails += field_differs("pseudo_header_sum", oldest.pseudo_header_sum,
                                 pseudo_header_sum);
          fails += field_differs("payload_length", oldest.payload_length, payload_length);
          fails += field_differs("payload_offset", oldest.payload_offset, payload_offset);
        end
      end
      if (in_valid && in_ready) parse_byte(frame_byte, last_byte);
      if (config_write) own_address = config_data;
    end
    results_due <= frame_results.size();
    mismatches <= fails;
  end

endmodule

>>> dv/tb_eth_ipv4_header_parser.sv
// testbench top for eth_ipv4_header_parser: builds ethernet frames, drives them a byte
// per item with random gaps and output stalls, and reports the verdict of eihp_parse_checker
// depends on eihp_pkg, eth_ipv4_header_parser, eihp_parse_checker
module tb_eth_ipv4_header_parser import eihp_pkg::*;;

  localparam int CYCLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  frame_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  verdict;
  logic [47:0] source_mac;
  logic [31:0] source_ip;
  logic [31:0] destination_ip;
  logic [15:0] pseudo_header_sum;
  logic [15:0] payload_length;
  logic [6:0]  payload_offset;
  logic        config_write = 1'b0;
  logic [31:0] config_data = 32'h0;

  int          results_due;
  int          mismatches;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          bytes_sent = 0;
  logic [31:0] local_addr = 32'h0;
  logic [7:0]  frame_q[$];
  logic [7:0]  ready_tick = 8'h00;
  logic [15:0] ready_pattern = 16'hFFFF;

  eth_ipv4_header_parser dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .frame_byte(frame_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .source_mac(source_mac), .source_ip(source_ip),
    .destination_ip(destination_ip), .pseudo_header_sum(pseudo_header_sum),
    .payload_length(payload_length), .payload_offset(payload_offset),
    .config_write(config_write), .config_data(config_data)
  );

  eihp_parse_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .frame_byte(frame_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .verdict(verdict), .source_mac(source_mac), .source_ip(source_ip),
    .destination_ip(destination_ip), .pseudo_header_sum(pseudo_header_sum),
    .payload_length(payload_length), .payload_offset(payload_offset),
    .config_write(config_write), .config_data(config_data),
    .results_due(results_due), .mismatches(mismatches)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("eth_ipv4_header_parser verification failed");
      $finish;
    end
  end

  // receiver stall pattern, redrawn each time ready_tick[5:0] reaches 63
  always @(posedge clk) begin
    ready_tick <= ready_tick + 8'd1;
    if (ready_tick[5:0] == 6'd63) begin
      case ($urandom_range(0, 3))
        0: ready_pattern <= 16'hFFFF;
        1: ready_pattern <= 16'h00FF;
        default: ready_pattern <= 16'($urandom) | 16'h0001;
      endcase
    end
    out_ready <= ready_pattern[ready_tick[3:0]];
  end

  task automatic push_byte(input logic [7:0] b, input logic mark);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    frame_byte <= b;
    last_byte <= mark;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_frame(input int keep);
    int n;
    int i;
    n = (keep > 0 && keep < frame_q.size()) ? keep : frame_q.size();
    for (i = 0; i < n; i++) push_byte(frame_q[i], i == n - 1);
    bytes_sent += n;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_local_address(input logic [31:0] addr);
    drain();
    config_write <= 1'b1;
    config_data <= addr;
    @(posedge clk);
    config_write <= 1'b0;
    local_addr = addr;
  endtask

  task automatic add_random(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  task automatic start_frame(input logic [15:0] etype);
    frame_q.delete();
    add_random(12);
    frame_q.push_back(etype[15:8]);
    frame_q.push_back(etype[7:0]);
  endtask

  task automatic ipv4_frame(input logic [3:0] ver, input logic [3:0] ihl,
                            input logic [15:0] total, input logic [15:0] frag,
                            input logic [7:0] proto, input logic [31:0] dst,
                            input bit bad_sum, input int extra);
    logic [7:0]  hdr[60];
    logic [31:0] acc;
    logic [15:0] csum;
    int          len;
    int          i;
    len = (ihl < 4'd5) ? 20 : 4 * int'(ihl);
    for (i = 0; i < 60; i++) hdr[i] = 8'($urandom);
    hdr[0] = {ver, ihl};
    {hdr[2], hdr[3]} = total;
    {hdr[6], hdr[7]} = frag;
    hdr[9] = proto;
    {hdr[10], hdr[11]} = 16'h0000;
    {hdr[16], hdr[17], hdr[18], hdr[19]} = dst;
    acc = 32'h0;
    for (i = 0; i < len; i += 2) acc += {16'h0, hdr[i], hdr[i + 1]};
    acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    acc = {16'h0, acc[15:0]} + {16'h0, acc[31:16]};
    csum = ~acc[15:0];
    if (bad_sum) csum ^= 16'(1 << $urandom_range(0, 15));
    {hdr[10], hdr[11]} = csum;
    start_frame(ETHERTYPE_IPV4);
    for (i = 0; i < len; i++) frame_q.push_back(hdr[i]);
    add_random(extra);
  endtask

  task automatic random_frame();
    int          sel;
    int          extra;
    int          keep;
    logic [3:0]  ver;
    logic [3:0]  ihl;
    logic [15:0] total;
    logic [15:0] frag;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [31:0] dst;
    bit          bad;
    sel = $urandom_range(0, 99) / 5;
    ver = 4'd4;
    ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    extra = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 110) : $urandom_range(0, 6);
    total = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'(4 * int'(ihl) + extra);
    frag = $urandom_range(0, 1) ? 16'h4000 : 16'h0000;
    proto = PROTO_UDP;
    dst = ($urandom_range(0, 3) == 0) ? BROADCAST_IPV4 : local_addr;
    bad = 1'b0;
    keep = 0;
    case (sel)
      8, 9: bad = 1'b1;
      10: begin
        frag = 16'($urandom);
        if ((frag & FRAG_MASK) == 16'h0) frag[0] = 1'b1;
      end
      11, 12: dst = $urandom;
      13: proto = 8'($urandom);
      14: begin
        ver = 4'($urandom);
        if (ver == 4'd4) ver = 4'd6;
      end
      15: ihl = 4'($urandom_range(0, 4));
      16: keep = $urandom_range(1, 13 + 4 * int'(ihl));
      default: ;
    endcase
    if (sel == 17) begin
      start_frame(ETHERTYPE_ARP);
      add_random(28 + extra);
    end else if (sel == 18) begin
      etype = 16'($urandom);
      if ($urandom_range(0, 1)) etype = ETHERTYPE_IPV4 ^ 16'(1 << $urandom_range(0, 15));
      if (etype == ETHERTYPE_IPV4 || etype == ETHERTYPE_ARP) etype ^= 16'h0001;
      start_frame(etype);
      add_random(20 + extra);
    end else if (sel == 19) begin
      frame_q.delete();
      add_random($urandom_range(1, 60));
    end else begin
      ipv4_frame(ver, ihl, total, frag, proto, dst, bad, extra);
    end
    send_frame(keep);
    if ($urandom_range(0, 9) == 0) drain();
  endtask

  initial begin
    int phase;
    int phase_start;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_local_address($urandom);

    ipv4_frame(4'd4, 4'd5, 16'd28, 16'h0000, PROTO_UDP, local_addr, 1'b0, 8);
    send_frame(0);
    ipv4_frame(4'd4, 4'd15, 16'd64, 16'h4000, PROTO_UDP, BROADCAST_IPV4, 1'b0, 4);
    send_frame(0);
    ipv4_frame(4'd4, 4'd5, 16'd28, 16'h0000, PROTO_UDP, local_addr, 1'b1, 8);
    send_frame(0);
    ipv4_frame(4'd4, 4'd5, 16'd28, 16'h2000, PROTO_UDP, local_addr, 1'b0, 8);
    send_frame(0);
    ipv4_frame(4'd4, 4'd5, 16'd28, 16'h9FFF, PROTO_UDP, local_addr, 1'b0, 8);
    send_frame(0);
    ipv4_frame(4'd4, 4'd5, 16'd28, 16'h0000, PROTO_UDP, ~local_addr, 1'b0, 8);
    send_frame(0);
    ipv4_frame(4'd4, 4'd5, 16'd28, 16'h0000, 8'h06, local_addr, 1'b0, 8);
    send_frame(0);
    ipv4_frame(4'd6, 4'd5, 16'd28, 16'h0000, PROTO_UDP, local_addr, 1'b0, 8);
    send_frame(0);
    ipv4_frame(4'd4, 4'd4, 16'd28, 16'h0000, PROTO_UDP, local_addr, 1'b0, 8);
    send_frame(0);
    ipv4_frame(4'd4, 4'd0, 16'd28, 16'h0000, PROTO_UDP, local_addr, 1'b0, 8);
    send_frame(0);
    start_frame(ETHERTYPE_ARP);
    add_random(28);
    send_frame(0);
    start_frame(16'h86DD);
    add_random(40);
    send_frame(0);
    // cut at a single byte, inside the source mac, inside the type, right after it,
    // and one byte short of the header
    ipv4_frame(4'd4, 4'd5, 16'd28, 16'h0000, PROTO_UDP, local_addr, 1'b0, 8);
    send_frame(1);
    send_frame(11);
    send_frame(13);
    send_frame(14);
    send_frame(33);
    ipv4_frame(4'd4, 4'd5, 16'd148, 16'h0000, PROTO_UDP, local_addr, 1'b0, 128);
    send_frame(0);
    ipv4_frame(4'd4, 4'd6, 16'd3, 16'h0000, PROTO_UDP, BROADCAST_IPV4, 1'b0, 0);
    send_frame(0);
    ipv4_frame(4'd4, 4'd5, 16'hFFFF, 16'h0000, PROTO_UDP, local_addr, 1'b0, 2);
    send_frame(0);
    frame_q.delete();
    repeat (40) frame_q.push_back(8'hFF);
    send_frame(0);
    frame_q.delete();
    repeat (40) frame_q.push_back(8'h00);
    send_frame(0);

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_local_address(32'h0000_0000);
        1: set_local_address(32'hFFFF_FFFF);
        default: set_local_address($urandom);
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 120) random_frame();
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("eth_ipv4_header_parser verification clean");
    end else begin
      $display("eth_ipv4_header_parser verification failed");
    end
    $finish;
  end

endmodule
